@@ rtl/serial_bank_switch_mapper_macros.svh @@
// Assertion macros for the serial bank switch mapper.
// Users must have clk and rst_n in scope.
`ifndef SERIAL_BANK_SWITCH_MAPPER_MACROS_SVH
`define SERIAL_BANK_SWITCH_MAPPER_MACROS_SVH

// Same-cycle implication.
`define SBSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SBSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/sbsm_pkg.sv @@
// Shared types and constants for the serial bank switch mapper.
// No dependencies.
package sbsm_pkg;

  localparam logic [1:0] LOCKOUT_CYCLES = 2'd3;
  localparam logic [2:0] SHIFT_BITS     = 3'd5;
  localparam logic [4:0] CTRL_RESET     = 5'h0C;

  localparam logic [1:0] CFG_ROM_MASK    = 2'd0;
  localparam logic [1:0] CFG_RAM_MASK    = 2'd1;
  localparam logic [1:0] CFG_RAM_PRESENT = 2'd2;
  localparam logic [1:0] CFG_RAM_EN_CTRL = 2'd3;

  localparam logic [1:0] REG_CTRL = 2'd0;
  localparam logic [1:0] REG_CHR0 = 2'd1;
  localparam logic [1:0] REG_CHR1 = 2'd2;
  localparam logic [1:0] REG_PRG  = 2'd3;

  typedef struct packed {
    logic        mode;
    logic [15:0] cpu_address;
    logic [7:0]  write_data;
  } in_t;

  typedef struct packed {
    logic       write_ignored;
    logic [4:0] prg_bank_low;
    logic [4:0] prg_bank_high;
    logic [4:0] chr_bank_low;
    logic [4:0] chr_bank_high;
    logic [1:0] mirroring;
    logic [1:0] ram_bank;
    logic       ram_enabled;
  } out_t;

  typedef struct packed {
    logic [7:0] rom_bank_mask;
    logic [1:0] ram_bank_mask;
    logic       ram_present;
    logic       ram_enable_control;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic value;
  } hp_load_t;

endpackage

@@ rtl/sbsm_cfg.sv @@
// Configuration registers of the serial bank switch mapper.
// Depends on sbsm_pkg.
module sbsm_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_wdata,
  output sbsm_pkg::cfg_t    cfg,
  output sbsm_pkg::hp_load_t hp_load
);
  import sbsm_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROM_MASK:    cfg_nxt.rom_bank_mask      = cfg_wdata;
        CFG_RAM_MASK:    cfg_nxt.ram_bank_mask      = cfg_wdata[1:0];
        CFG_RAM_PRESENT: cfg_nxt.ram_present        = cfg_wdata[0];
        CFG_RAM_EN_CTRL: cfg_nxt.ram_enable_control = cfg_wdata[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rom_bank_mask      <= 8'd15;
      cfg_r.ram_bank_mask      <= 2'd3;
      cfg_r.ram_present        <= 1'b1;
      cfg_r.ram_enable_control <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;
  // rom mask write reloads the high PRG bit from the new bit 4
  assign hp_load.load  = cfg_we && (cfg_index == CFG_ROM_MASK);
  assign hp_load.value = cfg_wdata[4];

endmodule

@@ rtl/sbsm_core.sv @@
// Mapper state and per-transaction update/decode of the bank map.
// Depends on sbsm_pkg and serial_bank_switch_mapper_macros.svh.
`include "serial_bank_switch_mapper_macros.svh"
module sbsm_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  sbsm_pkg::in_t      item,
  input  sbsm_pkg::cfg_t     cfg,
  input  sbsm_pkg::hp_load_t hp_load,
  output sbsm_pkg::out_t     res
);
  import sbsm_pkg::*;

  logic [1:0] lock_r, lock_nxt;
  logic [4:0] sv_r, sv_nxt;
  logic [2:0] sc_r, sc_nxt;
  logic [4:0] regs_r [4];
  logic [4:0] regs_nxt [4];
  logic       hp_r, hp_nxt;
  logic [1:0] rb_r, rb_nxt;
  logic       ren_r, ren_nxt;

  logic       ignored;
  logic       big_rom;
  logic [1:0] ram_sel;
  logic [4:0] sv_shift;
  logic [2:0] sc_inc;
  logic [1:0] sel;
  logic [4:0] hi;
  logic [4:0] prg;
  logic [4:0] ctrl;

  assign big_rom = cfg.rom_bank_mask[4];
  assign ram_sel = {~big_rom & cfg.ram_bank_mask[1], cfg.ram_bank_mask[0]}
                   & {2{cfg.ram_present}};
  assign sv_shift = sv_r | (5'(item.write_data[0]) << sc_r);
  assign sc_inc   = sc_r + 3'd1;
  assign sel      = item.cpu_address[14:13];

  always_comb begin
    lock_nxt = lock_r;
    sv_nxt   = sv_r;
    sc_nxt   = sc_r;
    regs_nxt = regs_r;
    hp_nxt   = hp_r;
    rb_nxt   = rb_r;
    ren_nxt  = ren_r;
    ignored  = 1'b0;
    if (hp_load.load) begin
      hp_nxt = hp_load.value;
    end else if (fire) begin
      if (!item.mode) begin
        if (lock_r != 2'd0) begin
          lock_nxt = lock_r - 2'd1;
        end
      end else if (lock_r != 2'd0) begin
        ignored = 1'b1;
      end else begin
        lock_nxt = LOCKOUT_CYCLES;
        if (item.write_data[7]) begin
          regs_nxt[REG_CTRL] = regs_r[REG_CTRL] | CTRL_RESET;
          sv_nxt = 5'd0;
          sc_nxt = 3'd0;
        end else if (sc_inc != SHIFT_BITS) begin
          sv_nxt = sv_shift;
          sc_nxt = sc_inc;
        end else begin
          sv_nxt = 5'd0;
          sc_nxt = 3'd0;
          regs_nxt[sel] = sv_shift;
          unique case (sel)
            REG_CTRL: begin
              if (ram_sel != 2'd0) rb_nxt = regs_r[REG_CHR0][4:3] & ram_sel;
            end
            REG_CHR0, REG_CHR1: begin
              if (ram_sel != 2'd0) rb_nxt = sv_shift[4:3] & ram_sel;
              if (big_rom) hp_nxt = sv_shift[4];
            end
            REG_PRG: begin
              if (cfg.ram_enable_control) ren_nxt = ~sv_shift[4];
            end
            default: ren_nxt = ren_r;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_r   <= 2'd0;
      sv_r     <= 5'd0;
      sc_r     <= 3'd0;
      regs_r[REG_CTRL] <= CTRL_RESET;
      regs_r[REG_CHR0] <= 5'd0;
      regs_r[REG_CHR1] <= 5'd0;
      regs_r[REG_PRG]  <= 5'd0;
      hp_r     <= 1'b0;
      rb_r     <= 2'd0;
      ren_r    <= 1'b1;
    end else begin
      lock_r <= lock_nxt;
      sv_r   <= sv_nxt;
      sc_r   <= sc_nxt;
      regs_r <= regs_nxt;
      hp_r   <= hp_nxt;
      rb_r   <= rb_nxt;
      ren_r  <= ren_nxt;
    end
  end

  // bank map decoded from the post-transaction state
  assign ctrl = regs_nxt[REG_CTRL];
  assign hi   = {big_rom & hp_nxt, 4'd0};
  assign prg  = hi | {1'b0, regs_nxt[REG_PRG][3:0]};

  always_comb begin
    res.write_ignored = ignored;
    if (!ctrl[3]) begin
      res.prg_bank_low  = prg & 5'h1E;
      res.prg_bank_high = prg | 5'h01;
    end else if (ctrl[2]) begin
      res.prg_bank_low  = prg;
      res.prg_bank_high = hi | 5'h0F;
    end else begin
      res.prg_bank_low  = hi;
      res.prg_bank_high = prg;
    end
    if (ctrl[4]) begin
      res.chr_bank_low  = regs_nxt[REG_CHR0];
      res.chr_bank_high = regs_nxt[REG_CHR1];
    end else begin
      res.chr_bank_low  = regs_nxt[REG_CHR0] & 5'h1E;
      res.chr_bank_high = regs_nxt[REG_CHR0] | 5'h01;
    end
    res.mirroring   = ctrl[1:0];
    res.ram_bank    = rb_nxt;
    res.ram_enabled = ren_nxt;
  end

  `SBSM_ASSERT_NOW(a_shift_count_range, 1'b1, sc_r < SHIFT_BITS, "shift count out of range")
  `SBSM_ASSERT_NOW(a_ignored_cause, fire && ignored, item.mode && (lock_r != 2'd0), "bad drop")
  `SBSM_ASSERT_NEXT(a_lockout_reload,
                    fire && item.mode && (lock_r == 2'd0) && !hp_load.load,
                    lock_r == LOCKOUT_CYCLES, "lockout not reloaded")

endmodule

@@ rtl/serial_bank_switch_mapper.sv @@
// Top level of the serial bank switch mapper: input stage, result stage.
// Depends on sbsm_pkg, sbsm_cfg, sbsm_core and the assertion macros.
//
//  channel | ports                          | direction
//  input   | in_valid, in_ready, in_data    | in
//  result  | out_valid, out_ready, out_data | out
//  config  | cfg_we, cfg_index, cfg_wdata   | in
//
// One transaction per cycle while the result register is not stalled; input register, then result register.
// The state update and bank decode sit between the two registers.
// A stalled result register holds one transaction in the input register.
// Synchronous active-low reset; control state and mapper state reset.
`include "serial_bank_switch_mapper_macros.svh"
module serial_bank_switch_mapper (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sbsm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output sbsm_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [7:0]     cfg_wdata
);
  import sbsm_pkg::*;

  logic     in_valid_r, in_valid_nxt;
  in_t      in_data_r;
  logic     out_valid_r, out_valid_nxt;
  out_t     out_data_r;
  logic     advance;
  cfg_t     cfg;
  hp_load_t hp_load;
  out_t     res;

  sbsm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .hp_load   (hp_load)
  );

  sbsm_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (advance),
    .item    (in_data_r),
    .cfg     (cfg),
    .hp_load (hp_load),
    .res     (res)
  );

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_ready) in_valid_nxt = in_valid;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) in_data_r <= in_data;
    if (advance) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SBSM_ASSERT_NOW(a_stall_cause, !in_ready, in_valid_r && out_valid_r && !out_ready, "spurious stall")
  `SBSM_ASSERT_NEXT(a_advance_fills, advance, out_valid_r, "result lost")
  `SBSM_ASSERT_NEXT(a_accept_fills, in_valid && in_ready, in_valid_r, "input lost")

endmodule
